// ----- rtl/ppsc_pkg.sv -----
// playback position and speed control: shared widths, codes, register reset values
// and the item and configuration structs
// no dependencies
`timescale 1ns / 1ps

package ppsc_pkg;

	// position format: unsigned fraction, 2^POS_FRAC_BITS is the whole melody
	localparam int POS_FRAC_BITS = 24;
	localparam int POS_W         = POS_FRAC_BITS + 1;

	localparam int STEP_W  = 16;
	localparam int FREQ_W  = 16;
	localparam int BASE_W  = 8;
	localparam int SPEED_W = 8;
	localparam int SAVE_W  = 8;
	localparam int RES_W   = 8;

	// step increment times step distance, then a signed sum with headroom
	localparam int PROD_W = POS_W + STEP_W;
	localparam int SUM_W  = PROD_W + 2;

	// save quantiser product
	localparam int SAVE_PROD_W = POS_W + RES_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (POS_W > FREQ_W) ? POS_W : FREQ_W;

	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

	// register reset values
	localparam logic [POS_W-1:0]  RST_STEP_INCREMENT = POS_W'(8192);
	localparam logic [STEP_W-1:0] RST_TOTAL_STEPS    = STEP_W'(4096);
	localparam logic              RST_LOOP_ENABLE    = 1'b1;
	localparam logic [BASE_W-1:0] RST_BASE_FREQ      = BASE_W'(100);
	localparam logic [FREQ_W-1:0] RST_MAX_FREQ       = FREQ_W'(2000);
	localparam logic [FREQ_W-1:0] RST_SUPERFINE_THR  = FREQ_W'(50);
	localparam logic [FREQ_W-1:0] RST_FINE_THR       = FREQ_W'(300);
	localparam logic [RES_W-1:0]  RST_SAVE_RES       = RES_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_INCREMENT      = 3'd0,
		REG_TOTAL_STEPS         = 3'd1,
		REG_LOOP_ENABLE         = 3'd2,
		REG_BASE_FREQ           = 3'd3,
		REG_MAX_FREQ            = 3'd4,
		REG_SUPERFINE_THRESHOLD = 3'd5,
		REG_FINE_THRESHOLD      = 3'd6,
		REG_SAVE_RESOLUTION     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_PLAY = 2'd1,
		CMD_STOP = 2'd2
	} play_cmd_t;

	// microstep mode: unchanged, half step, full step with 16 or 64 microsteps
	typedef enum logic [1:0] {
		MODE_UNCHANGED = 2'd0,
		MODE_HALF      = 2'd1,
		MODE_MICRO16   = 2'd2,
		MODE_MICRO64   = 2'd3
	} step_mode_t;

	typedef struct packed {
		logic [POS_W-1:0]  step_increment;
		logic [STEP_W-1:0] total_steps;
		logic              loop_enable;
		logic [BASE_W-1:0] base_freq;
		logic [FREQ_W-1:0] max_freq;
		logic [FREQ_W-1:0] superfine_threshold;
		logic [FREQ_W-1:0] fine_threshold;
		logic [RES_W-1:0]  save_resolution;
	} cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0]  current_step;
		logic               step_direction;
		logic               press_forward;
		logic               press_backward;
		logic               press_start;
		logic [SPEED_W-1:0] speed_setting;
		play_cmd_t          play_cmd;
	} tick_t;

	typedef struct packed {
		logic [FREQ_W-1:0] drive_freq;
		step_mode_t        step_mode;
		logic              pid_active;
		logic [POS_W-1:0]  position;
		logic              is_playing;
		logic              save_strobe;
		logic [SAVE_W-1:0] save_value;
	} result_t;

	// outcome of the position update
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             end_stop;
	} pos_upd_t;

	// outcome of the drive selection
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic              pid_on;
		step_mode_t        mode;
	} drive_t;

endpackage

// ----- rtl/ppsc_if.sv -----
// valid/ready channels for input ticks and result items
// depends on ppsc_pkg
`timescale 1ns / 1ps

interface ppsc_tick_if;
	logic             valid;
	logic             ready;
	ppsc_pkg::tick_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ppsc_result_if;
	logic              valid;
	logic              ready;
	ppsc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ppsc_cfg_regs.sv -----
// configuration register file, written through a plain write port
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ppsc_pkg::CFG_IDX_W-1:0]      index,
	input  logic [ppsc_pkg::CFG_DATA_W-1:0]     wr_data,
	output ppsc_pkg::cfg_t                      cfg
);

	ppsc_pkg::cfg_t cfg_q;

	// register writes, each field takes the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_increment      <= ppsc_pkg::RST_STEP_INCREMENT;
			cfg_q.total_steps         <= ppsc_pkg::RST_TOTAL_STEPS;
			cfg_q.loop_enable         <= ppsc_pkg::RST_LOOP_ENABLE;
			cfg_q.base_freq           <= ppsc_pkg::RST_BASE_FREQ;
			cfg_q.max_freq            <= ppsc_pkg::RST_MAX_FREQ;
			cfg_q.superfine_threshold <= ppsc_pkg::RST_SUPERFINE_THR;
			cfg_q.fine_threshold      <= ppsc_pkg::RST_FINE_THR;
			cfg_q.save_resolution     <= ppsc_pkg::RST_SAVE_RES;
		end else if (wr_en) begin
			case (ppsc_pkg::cfg_idx_t'(index))
				ppsc_pkg::REG_STEP_INCREMENT: begin
					cfg_q.step_increment <= wr_data[ppsc_pkg::POS_W-1:0];
				end
				ppsc_pkg::REG_TOTAL_STEPS: begin
					cfg_q.total_steps <= wr_data[ppsc_pkg::STEP_W-1:0];
				end
				ppsc_pkg::REG_LOOP_ENABLE: begin
					cfg_q.loop_enable <= wr_data[0];
				end
				ppsc_pkg::REG_BASE_FREQ: begin
					cfg_q.base_freq <= wr_data[ppsc_pkg::BASE_W-1:0];
				end
				ppsc_pkg::REG_MAX_FREQ: begin
					cfg_q.max_freq <= wr_data[ppsc_pkg::FREQ_W-1:0];
				end
				ppsc_pkg::REG_SUPERFINE_THRESHOLD: begin
					cfg_q.superfine_threshold <= wr_data[ppsc_pkg::FREQ_W-1:0];
				end
				ppsc_pkg::REG_FINE_THRESHOLD: begin
					cfg_q.fine_threshold <= wr_data[ppsc_pkg::FREQ_W-1:0];
				end
				ppsc_pkg::REG_SAVE_RESOLUTION: begin
					cfg_q.save_resolution <= wr_data[ppsc_pkg::RES_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/ppsc_pos_update.sv -----
// playback position update: wrapped step distance, scaling, end handling
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_pos_update (
	input  logic [ppsc_pkg::STEP_W-1:0] current_step,
	input  logic [ppsc_pkg::STEP_W-1:0] prev_step,
	input  logic                        step_direction,
	input  logic [ppsc_pkg::POS_W-1:0]  position,
	input  ppsc_pkg::cfg_t              cfg,
	output ppsc_pkg::pos_upd_t          upd
);

	logic                               moved;
	logic [ppsc_pkg::STEP_W-1:0]        raw_diff;
	logic [ppsc_pkg::STEP_W-1:0]        half_rev;
	logic [ppsc_pkg::STEP_W-1:0]        diff;
	logic [ppsc_pkg::PROD_W-1:0]        delta;
	logic [ppsc_pkg::SUM_W-1:0]         pos_ext;
	logic [ppsc_pkg::SUM_W-1:0]         delta_ext;
	logic signed [ppsc_pkg::SUM_W-1:0]  sum_s;
	logic signed [ppsc_pkg::SUM_W-1:0]  one_s;

	// shortest distance around the revolution
	always_comb begin
		moved    = current_step != prev_step;
		raw_diff = (current_step > prev_step) ? (current_step - prev_step)
		                                      : (prev_step - current_step);
		half_rev = cfg.total_steps >> 1;
		if (raw_diff > half_rev) begin
			diff = (raw_diff >= cfg.total_steps) ? '0 : (cfg.total_steps - raw_diff);
		end else begin
			diff = raw_diff;
		end
	end

	// scale by the step increment
	assign delta = ppsc_pkg::PROD_W'(cfg.step_increment) * ppsc_pkg::PROD_W'(diff);

	// signed move and wrap or clamp at the ends
	always_comb begin
		pos_ext   = ppsc_pkg::SUM_W'(position);
		delta_ext = ppsc_pkg::SUM_W'(delta);
		one_s     = $signed(ppsc_pkg::SUM_W'(ppsc_pkg::POS_ONE));
		sum_s     = step_direction ? $signed(pos_ext - delta_ext)
		                           : $signed(pos_ext + delta_ext);
		upd.end_stop = 1'b0;
		if (!moved) begin
			upd.position = position;
		end else if (sum_s > one_s) begin
			upd.position = '0;
			upd.end_stop = !cfg.loop_enable;
		end else if (sum_s[ppsc_pkg::SUM_W-1]) begin
			upd.position = cfg.loop_enable ? ppsc_pkg::POS_ONE : '0;
		end else begin
			upd.position = sum_s[ppsc_pkg::POS_W-1:0];
		end
	end

endmodule

// ----- rtl/ppsc_drive_sel.sv -----
// drive frequency, speed regulator enable and microstep mode selection
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_drive_sel (
	input  logic                         playing,
	input  logic                         press_forward,
	input  logic                         press_backward,
	input  logic [ppsc_pkg::SPEED_W-1:0] speed_setting,
	input  logic [ppsc_pkg::FREQ_W-1:0]  freq_prev,
	input  logic                         pid_prev,
	input  ppsc_pkg::cfg_t               cfg,
	output ppsc_pkg::drive_t             drive
);

	logic [ppsc_pkg::FREQ_W-1:0] speed_freq;
	logic [ppsc_pkg::FREQ_W-1:0] freq_sel;
	logic                        pid_sel;
	ppsc_pkg::step_mode_t        mode_sel;

	// base frequency times speed, 8 by 8 bits fits the frequency width
	assign speed_freq = ppsc_pkg::FREQ_W'(cfg.base_freq) * ppsc_pkg::FREQ_W'(speed_setting);

	// frequency and regulator from play state and seek buttons
	always_comb begin
		freq_sel = freq_prev;
		pid_sel  = pid_prev;
		if (playing) begin
			if (!press_backward && !press_forward) begin
				freq_sel = speed_freq;
				pid_sel  = 1'b0;
			end
		end else begin
			freq_sel = '0;
		end
		if (press_backward && !press_forward) begin
			freq_sel = '0;
		end
		if (press_forward && !press_backward) begin
			freq_sel = cfg.max_freq;
			pid_sel  = 1'b1;
		end
	end

	// microstep mode from the thresholds
	always_comb begin
		if (freq_sel == '0) begin
			mode_sel = ppsc_pkg::MODE_UNCHANGED;
		end else if (freq_sel <= cfg.superfine_threshold) begin
			mode_sel = ppsc_pkg::MODE_MICRO64;
		end else if (freq_sel <= cfg.fine_threshold) begin
			mode_sel = ppsc_pkg::MODE_MICRO16;
		end else begin
			mode_sel = ppsc_pkg::MODE_HALF;
		end
	end

	assign drive = '{freq: freq_sel, pid_on: pid_sel, mode: mode_sel};

endmodule

// ----- rtl/playback_position_speed_control_unit.sv -----
// playback position and speed control, top level
// depends on ppsc_pkg, ppsc_if, ppsc_cfg_regs, ppsc_pos_update, ppsc_drive_sel
//
// channel   dir  handshake     payload
// tick      in   valid/ready   ppsc_pkg::tick_t   (step, direction, buttons, speed, command)
// result    out  valid/ready   ppsc_pkg::result_t (freq, mode, pid, position, save)
// cfg       in   cfg_wr_en     cfg_index, cfg_wr_data (no read-back)
//
// an item is registered on entry and its result loads into the output register when stage
// one advances; one item per cycle is sustained while results are taken, the loop through
// position and play state closed combinationally between input and result register.
// the input register takes a new item while a finished result still waits, if it is empty.
// a stalled result holds both stages; reset clears state and restores register defaults.
`timescale 1ns / 1ps

module playback_position_speed_control_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	ppsc_tick_if.sink                         tick,
	ppsc_result_if.source                     result,
	input  logic                              cfg_wr_en,
	input  logic [ppsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppsc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

	ppsc_pkg::cfg_t    cfg;
	ppsc_pkg::tick_t   tick_s1;
	logic              valid_s1;
	ppsc_pkg::result_t res_s2;
	logic              valid_s2;

	logic [ppsc_pkg::STEP_W-1:0] prev_step_q;
	logic [ppsc_pkg::POS_W-1:0]  position_q;
	logic                        playing_q;
	logic [ppsc_pkg::SAVE_W-1:0] last_saved_q;
	logic [ppsc_pkg::FREQ_W-1:0] freq_q;
	logic                        pid_q;

	logic                             accept;
	logic                             advance;
	logic                             playing_cmd;
	logic                             playing_mid;
	logic                             three_button;
	logic [ppsc_pkg::SAVE_PROD_W-1:0] save_prod;
	logic [ppsc_pkg::SAVE_W-1:0]      save_val;
	logic [ppsc_pkg::POS_W-1:0]       pos_final;
	logic                             playing_final;
	ppsc_pkg::pos_upd_t               upd;
	ppsc_pkg::drive_t                 drive;

	ppsc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.index   (cfg_index),
		.wr_data (cfg_wr_data),
		.cfg     (cfg)
	);

	// handshake: stage one moves on when the output register is free or being taken
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign accept     = tick.valid && tick.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick.data;
		end
	end

	// play command
	always_comb begin
		case (tick_s1.play_cmd)
			ppsc_pkg::CMD_PLAY: playing_cmd = 1'b1;
			ppsc_pkg::CMD_STOP: playing_cmd = 1'b0;
			default:            playing_cmd = playing_q;
		endcase
	end

	// save value from the position held at the start of the tick
	assign save_prod = ppsc_pkg::SAVE_PROD_W'(position_q)
	                 * ppsc_pkg::SAVE_PROD_W'(cfg.save_resolution);
	assign save_val  = save_prod[ppsc_pkg::POS_FRAC_BITS +: ppsc_pkg::SAVE_W];

	ppsc_pos_update u_pos (
		.current_step   (tick_s1.current_step),
		.prev_step      (prev_step_q),
		.step_direction (tick_s1.step_direction),
		.position       (position_q),
		.cfg            (cfg),
		.upd            (upd)
	);

	assign playing_mid = playing_cmd && !upd.end_stop;

	ppsc_drive_sel u_drive (
		.playing        (playing_mid),
		.press_forward  (tick_s1.press_forward),
		.press_backward (tick_s1.press_backward),
		.speed_setting  (tick_s1.speed_setting),
		.freq_prev      (freq_q),
		.pid_prev       (pid_q),
		.cfg            (cfg),
		.drive          (drive)
	);

	// three-button reset after the drive choice
	assign three_button  = tick_s1.press_forward && tick_s1.press_backward
	                    && tick_s1.press_start;
	assign pos_final     = three_button ? '0 : upd.position;
	assign playing_final = three_button ? 1'b0 : playing_mid;

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_step_q  <= '0;
			position_q   <= '0;
			playing_q    <= 1'b0;
			last_saved_q <= '0;
			freq_q       <= '0;
			pid_q        <= 1'b0;
		end else if (advance) begin
			prev_step_q  <= tick_s1.current_step;
			position_q   <= pos_final;
			playing_q    <= playing_final;
			last_saved_q <= save_val;
			freq_q       <= drive.freq;
			pid_q        <= drive.pid_on;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.drive_freq  <= drive.freq;
			res_s2.step_mode   <= drive.mode;
			res_s2.pid_active  <= drive.pid_on;
			res_s2.position    <= pos_final;
			res_s2.is_playing  <= playing_final;
			res_s2.save_strobe <= save_val != last_saved_q;
			res_s2.save_value  <= save_val;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

endmodule
